// ----- rtl/piecewise_segment_blend_factor_unit_macros.svh -----
`ifndef PIECEWISE_SEGMENT_BLEND_FACTOR_UNIT_MACROS_SVH
`define PIECEWISE_SEGMENT_BLEND_FACTOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define PSBF_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("psbf check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define PSBF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("psbf check failed");

`endif

// ----- rtl/psbf_pkg.sv -----
package psbf_pkg;

   localparam int MATRIX_COUNT = 8;   // used table entries, 2..8
   localparam int REG_COUNT    = 8;
   localparam int INDEX_W      = 3;
   localparam int HEIGHT_W     = 24;
   localparam int SEG_W        = 3;
   localparam int FACTOR_W     = 17;
   localparam int DEN_W        = HEIGHT_W;
   localparam int REM_W        = HEIGHT_W + 1;
   localparam int DIV_STEPS    = FACTOR_W;

   // pair selection kind
   localparam logic [1:0] MODE_TOP = 2'd0;
   localparam logic [1:0] MODE_END = 2'd1;
   localparam logic [1:0] MODE_MID = 2'd2;

   typedef logic signed [HEIGHT_W-1:0] height_type;
   typedef logic [REG_COUNT-1:0][HEIGHT_W-1:0] height_tab_type;

   typedef struct packed {
      logic                valid;
      logic [SEG_W-1:0]    seg;
      logic [FACTOR_W-1:0] quot;
      logic [REM_W-1:0]    rem;
      logic [DEN_W-1:0]    den;
   } div_type;

endpackage

// ----- rtl/psbf_locate.sv -----
`include "piecewise_segment_blend_factor_unit_macros.svh"

module psbf_locate (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  psbf_pkg::height_type   in_height,
   input  psbf_pkg::height_tab_type refs,
   output psbf_pkg::div_type      out_w
);
   import psbf_pkg::*;

   // stage 1: compare against every entry, pick the pair
   logic [MATRIX_COUNT-1:0] ge;
   logic                    le_last;
   logic                    found;
   logic [1:0]              s1_mode_in, s1_mode_ff;
   logic [SEG_W-1:0]        s1_seg_in, s1_seg_ff;
   logic [HEIGHT_W-1:0]     s1_h_in, s1_h_ff;
   logic [HEIGHT_W-1:0]     s1_l_in, s1_l_ff;
   logic [HEIGHT_W-1:0]     s1_height_ff;
   logic                    s1_valid_ff;

   always_comb begin
      for (int i = 0; i < MATRIX_COUNT; i++) begin
         ge[i] = $signed(in_height) >= $signed(refs[i]);
      end
      le_last = $signed(in_height) <= $signed(refs[MATRIX_COUNT-1]);

      found   = 1'b0;
      s1_h_in = '0;
      s1_l_in = '0;
      s1_seg_in = '0;
      for (int i = 1; i < MATRIX_COUNT; i++) begin
         if (ge[i] && !found) begin
            s1_h_in   = refs[i-1];
            s1_l_in   = refs[i];
            s1_seg_in = SEG_W'(i - 1);
         end
         found = found | ge[i];
      end

      priority if (ge[0]) begin
         s1_mode_in = MODE_TOP;
      end else if (le_last) begin
         s1_mode_in = MODE_END;
      end else begin
         s1_mode_in = MODE_MID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid;
         s1_mode_ff   <= s1_mode_in;
         s1_seg_ff    <= s1_seg_in;
         s1_h_ff      <= s1_h_in;
         s1_l_ff      <= s1_l_in;
         s1_height_ff <= in_height;
      end
   end

   // stage 2: numerator and divisor; the end cases become 0/1 and 1/1
   logic [HEIGHT_W:0] num_full;
   logic [HEIGHT_W:0] den_full;
   div_type           s2_in, s2_ff;

   always_comb begin
      num_full = {s1_h_ff[HEIGHT_W-1], s1_h_ff} - {s1_height_ff[HEIGHT_W-1], s1_height_ff};
      den_full = {s1_h_ff[HEIGHT_W-1], s1_h_ff} - {s1_l_ff[HEIGHT_W-1], s1_l_ff};
      s2_in.valid = s1_valid_ff;
      s2_in.quot  = '0;
      unique case (s1_mode_ff)
         MODE_MID: begin
            s2_in.seg = s1_seg_ff;
            s2_in.rem = REM_W'(num_full);
            s2_in.den = den_full[DEN_W-1:0];
         end
         MODE_END: begin
            s2_in.seg = SEG_W'(MATRIX_COUNT - 2);
            s2_in.rem = REM_W'(1);
            s2_in.den = DEN_W'(1);
         end
         default: begin
            s2_in.seg = '0;
            s2_in.rem = '0;
            s2_in.den = DEN_W'(1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else begin
         s2_ff <= s2_in;
      end
   end

   assign out_w = s2_ff;

   `PSBF_ASSERT_NOW(a_mid_below_upper, s1_valid_ff && (s1_mode_ff == MODE_MID), $signed(s1_height_ff) < $signed(s1_h_ff))
   `PSBF_ASSERT_NOW(a_num_le_den, s2_ff.valid, s2_ff.rem <= REM_W'(s2_ff.den))
   `PSBF_ASSERT_NOW(a_den_nonzero, s2_ff.valid, s2_ff.den != '0)

endmodule

// ----- rtl/psbf_div_stage.sv -----
`include "piecewise_segment_blend_factor_unit_macros.svh"

module psbf_div_stage (
   input  logic              clock,
   input  logic              reset,
   input  psbf_pkg::div_type in_w,
   output psbf_pkg::div_type out_w
);
   import psbf_pkg::*;

   // one restoring step: compare, subtract, shift; one quotient bit per stage
   logic [REM_W:0]   diff;
   logic             qbit;
   logic [REM_W-1:0] rem_sub;
   div_type          out_in, out_ff;

   always_comb begin
      diff    = {1'b0, in_w.rem} - {2'b00, in_w.den};
      qbit    = ~diff[REM_W];
      rem_sub = qbit ? diff[REM_W-1:0] : in_w.rem;
      out_in.valid = in_w.valid;
      out_in.seg   = in_w.seg;
      out_in.den   = in_w.den;
      out_in.quot  = {in_w.quot[FACTOR_W-2:0], qbit};
      out_in.rem   = {rem_sub[REM_W-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff <= out_in;
      end
   end

   assign out_w = out_ff;

   `PSBF_ASSERT_NOW(a_in_den_nonzero, in_w.valid, in_w.den != '0)
   `PSBF_ASSERT_NOW(a_in_rem_bound, in_w.valid, in_w.rem < {in_w.den, 1'b0})
   `PSBF_ASSERT_NOW(a_out_rem_bound, out_ff.valid, out_ff.rem < {out_ff.den, 1'b0})

endmodule

// ----- rtl/piecewise_segment_blend_factor_unit.sv -----
// Places an eye height in the descending reference table and returns the lower
// segment index and the Q1.16 blend factor (65536 = one). Fully pipelined: a
// word is taken on every cycle that start is high, busy never rises, and each
// result appears on rsp_valid in order, after two locate stages
// (compare/select, then subtract) and a 17-stage restoring divider that
// settles one quotient bit per stage. The receiver cannot stall; results are
// never held. Write the reference registers only while no word is in flight.
module piecewise_segment_blend_factor_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [psbf_pkg::HEIGHT_W-1:0] req_eye_height,
   output logic                            rsp_valid,
   output logic [psbf_pkg::SEG_W-1:0]      rsp_segment_index,
   output logic [psbf_pkg::FACTOR_W-1:0]   rsp_blend_factor,
   input  logic                            csr_we,
   input  logic [psbf_pkg::INDEX_W-1:0]    csr_index,
   input  logic [psbf_pkg::HEIGHT_W-1:0]   csr_wdata
);
   import psbf_pkg::*;

   height_tab_type ref_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_height_ff <= '0;
      end else if (csr_we) begin
         ref_height_ff[csr_index] <= csr_wdata;
      end
   end

   assign busy = 1'b0;

   div_type pipe_w [DIV_STEPS+1];

   psbf_locate u_locate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_height (req_eye_height),
      .refs      (ref_height_ff),
      .out_w     (pipe_w[0])
   );

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      psbf_div_stage u_step (
         .clock (clock),
         .reset (reset),
         .in_w  (pipe_w[k]),
         .out_w (pipe_w[k+1])
      );
   end

   assign rsp_valid         = pipe_w[DIV_STEPS].valid;
   assign rsp_segment_index = pipe_w[DIV_STEPS].seg;
   assign rsp_blend_factor  = pipe_w[DIV_STEPS].quot;

endmodule
